FILE: rtl/cks_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and channel arithmetic for the cross-kernel sharpen filter.
package cks_pkg;

    typedef logic [23:0] pix_t;

    // Register indexes of the configuration port (byte address 4*index).
    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int         CFG_AW           = 3;
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

    // Which of the up to three results of one pixel is being produced.
    typedef enum logic [2:0] {
        KIND_ABOVE = 3'b001,   // pixel above the arriving one
        KIND_LEFT  = 3'b010,   // last-row pixel to the left
        KIND_FINAL = 3'b100    // final pixel of the frame
    } kind_t;

    // Front state: normal streaming, or reloading the window after a size change.
    typedef enum logic [1:0] {
        FST_RUN   = 2'b01,
        FST_FETCH = 2'b10
    } fst_t;

    // One classified pixel: every operand its results need, plus which results exist.
    typedef struct packed {
        pix_t px;
        pix_t ctr;
        pix_t up;
        pix_t lf;
        pix_t rt;
        pix_t pp;
        pix_t pctr;
        pix_t lfb;
        logic has_above;
        logic has_left;
        logic has_final;
    } job_t;

    function automatic logic [7:0] sharp_ch(input logic [7:0] c, input logic [7:0] u,
                                            input logic [7:0] d, input logic [7:0] l,
                                            input logic [7:0] r);
        logic [10:0] pos;
        logic [9:0]  neg;
        logic [10:0] diff;
        pos  = {1'b0, c, 2'b00} + {3'b000, c};
        neg  = {2'b00, u} + {2'b00, d} + {2'b00, l} + {2'b00, r};
        diff = pos - {1'b0, neg};
        if ({1'b0, neg} >= pos)
        begin
            sharp_ch = 8'd0;
        end
        else if (diff > 11'd255)
        begin
            sharp_ch = 8'hFF;
        end
        else
        begin
            sharp_ch = diff[7:0];
        end
    endfunction

    function automatic pix_t sharpen(input pix_t c, input pix_t u, input pix_t d,
                                     input pix_t l, input pix_t r);
        pix_t res;
        res[23:16] = sharp_ch(c[23:16], u[23:16], d[23:16], l[23:16], r[23:16]);
        res[15:8]  = sharp_ch(c[15:8], u[15:8], d[15:8], l[15:8], r[15:8]);
        res[7:0]   = sharp_ch(c[7:0], u[7:0], d[7:0], l[7:0], r[7:0]);
        sharpen    = res;
    endfunction

endpackage

FILE: rtl/cks_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
module cks_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cks_front.sv
`timescale 1ns / 1ps
// Front end: raster position tracking, line stores, neighbor window and pixel classification.
module cks_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    red_in,
    input  logic [7:0]    green_in,
    input  logic [7:0]    blue_in,
    input  logic [11:0]   frame_width,
    input  logic [15:0]   frame_height,
    input  logic          q_full,
    output logic          push,
    output cks_pkg::job_t job
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WCW  = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WCW > 12) ? WCW : 12;

    cks_pkg::fst_t   state_reg, state_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [15:0]     row_reg, row_next;
    logic [CW-1:0]   tag_reg, tag_next;
    logic            wrap_sel_reg, wrap_sel_next;
    cks_pkg::pix_t   win_ctr_reg, win_ctr_next;
    cks_pkg::pix_t   px_row0_reg, px_row1_reg, ctr_col0_reg;
    cks_pkg::pix_t   pp_reg, ppp_reg, pctr_reg;

    logic [CMPW-1:0] fw_ext;
    logic [WCW-1:0]  w_eff;
    logic [15:0]     h_eff;
    logic            col_wrap;
    logic [CW-1:0]   c_act;
    logic [16:0]     r_pre;
    logic [15:0]     r_act;
    logic [WCW-1:0]  c1;
    logic [16:0]     r1;
    logic            c_last, c_first, c_is1, r_last, r_first, r_is1;
    logic            mismatch, acc;
    cks_pkg::pix_t   px, up_win, rt_win, up_rdata, mid_rdata;
    logic            up_re, mid_re;
    logic [CW-1:0]   up_raddr, mid_raddr;

    // Clamp the frame size to at least 2x2 and the width to what the line stores can hold.
    always_comb
    begin
        fw_ext = CMPW'(frame_width);
        if (fw_ext < CMPW'(2))
        begin
            w_eff = WCW'(2);
        end
        else if (fw_ext > CMPW'(MAX_WIDTH))
        begin
            w_eff = WCW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WCW'(fw_ext);
        end
        h_eff = (frame_height < 16'd2) ? 16'd2 : frame_height;
    end

    // Position of the arriving pixel, wrapping first if the size shrank under us.
    always_comb
    begin
        col_wrap = WCW'(col_reg) >= w_eff;
        c_act    = col_wrap ? '0 : col_reg;
        r_pre    = col_wrap ? ({1'b0, row_reg} + 17'd1) : {1'b0, row_reg};
        r_act    = (r_pre >= {1'b0, h_eff}) ? 16'd0 : r_pre[15:0];
        c1       = WCW'(c_act) + WCW'(1);
        r1       = {1'b0, r_act} + 17'd1;
        c_last   = c1 == w_eff;
        c_first  = c_act == '0;
        c_is1    = c_act == CW'(1);
        r_last   = r1 == {1'b0, h_eff};
        r_first  = r_act == 16'd0;
        r_is1    = r_act == 16'd1;
    end

    assign mismatch = c_act != tag_reg;
    assign in_stall = (state_reg != cks_pkg::FST_RUN) || mismatch || q_full;
    assign acc      = in_valid && !in_stall;
    assign px       = {red_in, green_in, blue_in};

    // At a row start the window comes from the row-start registers, else from the stores.
    assign up_win = wrap_sel_reg ? ctr_col0_reg : up_rdata;
    assign rt_win = wrap_sel_reg ? px_row1_reg : mid_rdata;

    always_comb
    begin
        job.px        = px;
        job.ctr       = win_ctr_reg;
        job.up        = r_is1 ? win_ctr_reg : up_win;
        job.lf        = c_first ? win_ctr_reg : pctr_reg;
        job.rt        = c_last ? win_ctr_reg : rt_win;
        job.pp        = pp_reg;
        job.pctr      = pctr_reg;
        job.lfb       = c_is1 ? pp_reg : ppp_reg;
        job.has_above = !r_first;
        job.has_left  = r_last && !c_first;
        job.has_final = r_last && c_last;
    end

    assign push = acc && (job.has_above || job.has_left || job.has_final);

    // Store reads: prefetch the next column on a transfer, reload after a size change.
    always_comb
    begin
        up_re     = 1'b0;
        mid_re    = 1'b0;
        up_raddr  = c1[CW-1:0];
        mid_raddr = c_act + CW'(2);
        if (state_reg == cks_pkg::FST_RUN && mismatch)
        begin
            up_re     = 1'b1;
            mid_re    = 1'b1;
            up_raddr  = c_act;
            mid_raddr = c_act;
        end
        else if (state_reg == cks_pkg::FST_FETCH)
        begin
            mid_re    = 1'b1;
            mid_raddr = c_act + CW'(1);
        end
        else if (acc && !c_last)
        begin
            up_re  = 1'b1;
            mid_re = 1'b1;
        end
    end

    cks_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .clk   (clk),
        .we    (acc),
        .waddr (c_act),
        .wdata (win_ctr_reg),
        .re    (up_re),
        .raddr (up_raddr),
        .rdata (up_rdata)
    );

    cks_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_middle_ram (
        .clk   (clk),
        .we    (acc),
        .waddr (c_act),
        .wdata (px),
        .re    (mid_re),
        .raddr (mid_raddr),
        .rdata (mid_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        tag_next      = tag_reg;
        wrap_sel_next = wrap_sel_reg;
        win_ctr_next  = win_ctr_reg;
        case (state_reg)
            cks_pkg::FST_RUN:
            begin
                if (mismatch)
                begin
                    state_next = cks_pkg::FST_FETCH;
                end
                else if (acc)
                begin
                    col_next      = c_last ? '0 : c1[CW-1:0];
                    row_next      = c_last ? (r_last ? 16'd0 : r1[15:0]) : r_act;
                    tag_next      = c_last ? '0 : c1[CW-1:0];
                    wrap_sel_next = c_last;
                    win_ctr_next  = c_last ? px_row0_reg : rt_win;
                end
            end
            cks_pkg::FST_FETCH:
            begin
                state_next    = cks_pkg::FST_RUN;
                tag_next      = c_act;
                wrap_sel_next = 1'b0;
                win_ctr_next  = mid_rdata;
            end
            default:
            begin
                state_next = cks_pkg::FST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cks_pkg::FST_RUN;
            col_reg      <= '0;
            row_reg      <= 16'd0;
            tag_reg      <= '0;
            wrap_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            tag_reg      <= tag_next;
            wrap_sel_reg <= wrap_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_ctr_reg <= win_ctr_next;
        if (acc)
        begin
            pp_reg   <= px;
            ppp_reg  <= pp_reg;
            pctr_reg <= win_ctr_reg;
            if (c_first)
            begin
                px_row0_reg  <= px;
                ctr_col0_reg <= win_ctr_reg;
            end
            if (c_is1)
            begin
                px_row1_reg <= px;
            end
        end
    end

endmodule

FILE: rtl/cks_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified pixels between the front and back ends.
module cks_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cks_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output cks_pkg::job_t q_data
);

    cks_pkg::job_t ent_reg [2];
    logic          wptr_reg, rptr_reg;
    logic [1:0]    cnt_reg, cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_data  = ent_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/cks_back.sv
`timescale 1ns / 1ps
// Back end: walks the results of each queued pixel, applies the kernel, holds the output.
module cks_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  cks_pkg::job_t q_data,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    red_out,
    output logic [7:0]    green_out,
    output logic [7:0]    blue_out,
    output logic          last_of_run,
    output logic          frame_end
);

    logic [2:0]     done_reg, done_next;
    logic [2:0]     remain;
    cks_pkg::kind_t kind;
    logic           last, load;
    cks_pkg::pix_t  c, u, d, l, r, res;
    logic           ovalid_reg;
    cks_pkg::pix_t  pix_reg;
    logic           last_reg, fend_reg;

    assign remain = {q_data.has_final, q_data.has_left, q_data.has_above} & ~done_reg;

    // Results leave in order: above, left, final.
    always_comb
    begin
        if (remain[0])
        begin
            kind = cks_pkg::KIND_ABOVE;
        end
        else if (remain[1])
        begin
            kind = cks_pkg::KIND_LEFT;
        end
        else
        begin
            kind = cks_pkg::KIND_FINAL;
        end
    end

    assign last  = remain == kind;
    assign load  = q_valid && (!ovalid_reg || !out_stall);
    assign q_pop = load && last;

    always_comb
    begin
        done_next = done_reg;
        if (load)
        begin
            done_next = last ? 3'b000 : (done_reg | kind);
        end
    end

    always_comb
    begin
        case (kind)
            cks_pkg::KIND_ABOVE:
            begin
                c = q_data.ctr;
                u = q_data.up;
                d = q_data.px;
                l = q_data.lf;
                r = q_data.rt;
            end
            cks_pkg::KIND_LEFT:
            begin
                c = q_data.pp;
                u = q_data.pctr;
                d = q_data.pp;
                l = q_data.lfb;
                r = q_data.px;
            end
            cks_pkg::KIND_FINAL:
            begin
                c = q_data.px;
                u = q_data.ctr;
                d = q_data.px;
                l = q_data.pp;
                r = q_data.px;
            end
            default:
            begin
                c = q_data.ctr;
                u = q_data.up;
                d = q_data.px;
                l = q_data.lf;
                r = q_data.rt;
            end
        endcase
        res = cks_pkg::sharpen(c, u, d, l, r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 3'b000;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg  <= res;
            last_reg <= last;
            fend_reg <= kind == cks_pkg::KIND_FINAL;
        end
    end

    assign out_valid   = ovalid_reg;
    assign red_out     = pix_reg[23:16];
    assign green_out   = pix_reg[15:8];
    assign blue_out    = pix_reg[7:0];
    assign last_of_run = last_reg;
    assign frame_end   = fend_reg;

endmodule

FILE: rtl/cross_kernel_sharpen_filter.sv
`timescale 1ns / 1ps
// Cross-kernel 3x3 RGB sharpen filter: top level with configuration registers.
//
// Pixels enter in raster order on the in_valid/in_stall channel; a transfer
// happens on a rising edge with in_valid high and in_stall low. Each result
// leaves on out_valid/out_stall with the three sharpened channels, last_of_run
// on the last result a pixel causes and frame_end on the frame's final pixel.
// A pixel releases the one above it, so row 0 gives no results; in the last
// row each pixel also releases its left neighbor, and the final pixel itself.
// Throughput: one pixel per cycle while in_stall stays low, set by one read of
// each line store per pixel. In the last row a pixel causes up to two results
// (three for the final pixel), so the input stalls once the two-entry queue fills.
// out_valid rises after the releasing pixel has passed the queue and the output
// register. A frame_width write that pushes the position into the next row makes
// the front reload its neighbor window from the line stores, stalling the input.
// When out_stall is high the output register holds; the queue absorbs up to two
// more pixels before in_stall rises. Reset restores 640x480, starts at row 0,
// column 0 and empties the queue; the line stores are not cleared.
// frame_width (byte address 0) and frame_height (address 4) may be written
// only while the block is idle.
module cross_kernel_sharpen_filter #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cks_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 red_in,
    input  logic [7:0]                 green_in,
    input  logic [7:0]                 blue_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 red_out,
    output logic [7:0]                 green_out,
    output logic [7:0]                 blue_out,
    output logic                       last_of_run,
    output logic                       frame_end
);

    logic [11:0]   fw_reg;
    logic [15:0]   fh_reg;
    logic          cfg_wr;
    logic          q_full, q_push, q_pop, q_valid;
    cks_pkg::job_t push_job, head_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes: only bit 2 of the byte address selects a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= cks_pkg::FRAME_WIDTH_RST;
            fh_reg <= cks_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                cks_pkg::REG_FRAME_WIDTH:
                begin
                    fw_reg <= pwdata[11:0];
                end
                cks_pkg::REG_FRAME_HEIGHT:
                begin
                    fh_reg <= pwdata[15:0];
                end
                default:
                begin
                    fw_reg <= fw_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            cks_pkg::REG_FRAME_WIDTH:
            begin
                prdata = {20'd0, fw_reg};
            end
            cks_pkg::REG_FRAME_HEIGHT:
            begin
                prdata = {16'd0, fh_reg};
            end
            default:
            begin
                prdata = 32'd0;
            end
        endcase
    end

    // Front end: track position, keep the line stores, classify each pixel.
    cks_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .frame_width  (fw_reg),
        .frame_height (fh_reg),
        .q_full       (q_full),
        .push         (q_push),
        .job          (push_job)
    );

    // Decouple the stallable one-pixel-per-cycle front from the stallable result-per-cycle back.
    cks_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (head_job)
    );

    // Back end: emit each queued pixel's results through the output register.
    cks_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (head_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

endmodule
